// ===== design/pbrd_pkg.sv =====
// Package with shared constants and controller/datapath handshake types for the PackBits row decoder.
`default_nettype none
package pbrd_pkg;

	// Decode modes of the row state.
	localparam logic [1:0] MODE_CTRL = 2'd0;
	localparam logic [1:0] MODE_LIT  = 2'd1;
	localparam logic [1:0] MODE_REP  = 2'd2;

	// Control byte that does nothing.
	localparam logic [7:0] CTRL_NOOP = 8'h80;
	// A repeat control byte c gives REP_BASE - c copies.
	localparam logic [8:0] REP_BASE = 9'd257;
	// Row width after reset.
	localparam logic [15:0] ROW_WIDTH_RESET = 16'd2550;

	// Byte counts carried in a result.
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // input transfer this cycle
		logic rep_step; // load the next repeat result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic emit_now; // the offered item gives one result at once
		logic goes_rep; // the offered item starts a repeat burst
		logic rep_last; // the pending repeat result is the final one
	} stat_t;

endpackage
`default_nettype wire

// ===== design/pbrd_if.sv =====
// Channel interfaces of the PackBits row decoder: input, output and configuration.
`default_nettype none

// Compressed byte channel.
interface pbrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       row_end;
	modport source (output valid, output in_byte, output row_end, input ready);
	modport sink (input valid, input in_byte, input row_end, output ready);
endinterface

// Decoded result channel.
interface pbrd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte_first;
	logic [7:0] out_byte_second;
	logic [1:0] byte_count;
	logic       row_done;
	logic       row_status;
	logic       last_of_item;
	modport source (output valid, output out_byte_first, output out_byte_second,
		output byte_count, output row_done, output row_status, output last_of_item,
		input ready);
	modport sink (input valid, input out_byte_first, input out_byte_second,
		input byte_count, input row_done, input row_status, input last_of_item,
		output ready);
endinterface

// Row width configuration write channel.
interface pbrd_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] row_width_bytes;
	modport source (output valid, output row_width_bytes, input ready);
	modport sink (input valid, input row_width_bytes, output ready);
endinterface
`default_nettype wire

// ===== design/pbrd_ctrl.sv =====
// Controller state machine: input and output handshakes and repeat burst sequencing.
`default_nettype none
module pbrd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire pbrd_pkg::stat_t st,
	output pbrd_pkg::cmd_t      cmd
);

	localparam logic ST_IN  = 1'b0;
	localparam logic ST_REP = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_free;
	logic out_load;

	// The output register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.rep_step = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			ST_IN: begin
				in_ready   = out_free;
				cmd.accept = in_valid && out_free;
				out_load   = cmd.accept && st.emit_now;
				if (cmd.accept && st.goes_rep) begin
					state_d = ST_REP;
				end
			end
			ST_REP: begin
				cmd.rep_step = out_free;
				out_load     = out_free;
				if (out_free && st.rep_last) begin
					state_d = ST_IN;
				end
			end
			default: begin
				state_d = ST_IN;
			end
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/pbrd_dp.sv =====
// Datapath: row decode state, run length checks, repeat counter and output payload register.
`default_nettype none
module pbrd_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pbrd_pkg::cmd_t  cmd,
	output pbrd_pkg::stat_t      st,
	input  wire logic [7:0]      in_byte,
	input  wire logic            row_end,
	input  wire logic            cfg_write,
	input  wire logic [15:0]     cfg_width,
	output logic [7:0]           out_byte_first,
	output logic [7:0]           out_byte_second,
	output logic [1:0]           byte_count,
	output logic                 row_done,
	output logic                 row_status,
	output logic                 last_of_item
);

	// Configuration and row state.
	logic [15:0] width_q;
	logic [1:0]  mode_q;
	logic [7:0]  lit_left_q;
	logic [7:0]  rep_cnt_q;
	logic [15:0] bytes_out_q;
	logic        failed_q;

	// Repeat burst state.
	logic [7:0]  rep_left_q;
	logic [7:0]  rep_byte_q;
	logic        rep_end_q;
	logic        rep_status_q;

	// Output payload.
	logic [7:0]  first_q;
	logic [7:0]  second_q;
	logic [1:0]  count_q;
	logic        done_q;
	logic        status_q;
	logic        last_q;

	// Decode of the offered byte.
	logic [1:0]  mode_d;
	logic [7:0]  lit_left_d;
	logic [7:0]  rep_cnt_d;
	logic [15:0] bytes_out_d;
	logic        failed_d;
	logic [8:0]  run_len;
	logic [16:0] run_sum;
	logic        run_fits;
	logic        is_lit;
	logic        is_rep;
	logic        bad_row;
	logic [1:0]  rep_chunk;

	assign is_lit  = !failed_q && (mode_q == pbrd_pkg::MODE_LIT);
	assign is_rep  = !failed_q && (mode_q == pbrd_pkg::MODE_REP);

	assign st.goes_rep = is_rep;
	assign st.emit_now = is_lit || (row_end && !is_rep);
	assign st.rep_last = (rep_left_q <= 8'd2);

	// Run length of a control byte and the check against the row width.
	always_comb begin
		if (in_byte < pbrd_pkg::CTRL_NOOP) begin
			run_len = {1'b0, in_byte} + 9'd1;
		end else begin
			run_len = pbrd_pkg::REP_BASE - {1'b0, in_byte};
		end
		run_sum  = {1'b0, bytes_out_q} + {8'd0, run_len};
		run_fits = (run_sum <= {1'b0, width_q});
	end

	// Row state after the offered byte.
	always_comb begin
		mode_d      = mode_q;
		lit_left_d  = lit_left_q;
		rep_cnt_d   = rep_cnt_q;
		bytes_out_d = bytes_out_q;
		failed_d    = failed_q;
		if (is_lit) begin
			bytes_out_d = bytes_out_q + 16'd1;
			lit_left_d  = lit_left_q - 8'd1;
			if (lit_left_q == 8'd1) begin
				mode_d = pbrd_pkg::MODE_CTRL;
			end
		end else if (is_rep) begin
			bytes_out_d = bytes_out_q + {8'd0, rep_cnt_q};
			rep_cnt_d   = 8'd0;
			mode_d      = pbrd_pkg::MODE_CTRL;
		end else if (!failed_q && (in_byte != pbrd_pkg::CTRL_NOOP)) begin
			if (!run_fits) begin
				failed_d = 1'b1;
			end else if (in_byte < pbrd_pkg::CTRL_NOOP) begin
				lit_left_d = run_len[7:0];
				mode_d     = pbrd_pkg::MODE_LIT;
			end else begin
				rep_cnt_d = run_len[7:0];
				mode_d    = pbrd_pkg::MODE_REP;
			end
		end
		bad_row = failed_d || (mode_d != pbrd_pkg::MODE_CTRL) || (bytes_out_d != width_q);
	end

	// Size of the next repeat result.
	assign rep_chunk = st.rep_last ? rep_left_q[1:0] : pbrd_pkg::CNT_TWO;

	// Configuration register and row state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= pbrd_pkg::ROW_WIDTH_RESET;
			mode_q      <= pbrd_pkg::MODE_CTRL;
			lit_left_q  <= 8'd0;
			rep_cnt_q   <= 8'd0;
			bytes_out_q <= 16'd0;
			failed_q    <= 1'b0;
			rep_left_q  <= 8'd0;
			rep_end_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				width_q <= cfg_width;
			end
			if (cmd.accept) begin
				if (row_end) begin
					mode_q      <= pbrd_pkg::MODE_CTRL;
					lit_left_q  <= 8'd0;
					rep_cnt_q   <= 8'd0;
					bytes_out_q <= 16'd0;
					failed_q    <= 1'b0;
				end else begin
					mode_q      <= mode_d;
					lit_left_q  <= lit_left_d;
					rep_cnt_q   <= rep_cnt_d;
					bytes_out_q <= bytes_out_d;
					failed_q    <= failed_d;
				end
				if (is_rep) begin
					rep_left_q <= rep_cnt_q;
					rep_end_q  <= row_end;
				end
			end else if (cmd.rep_step) begin
				rep_left_q <= rep_left_q - {6'd0, rep_chunk};
			end
		end
	end

	// Repeat byte and its row status, held for the burst.
	always_ff @(posedge clk) begin
		if (cmd.accept && is_rep) begin
			rep_byte_q   <= in_byte;
			rep_status_q <= bad_row;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.accept && st.emit_now) begin
			first_q  <= is_lit ? in_byte : 8'd0;
			second_q <= 8'd0;
			count_q  <= is_lit ? pbrd_pkg::CNT_ONE : pbrd_pkg::CNT_NONE;
			done_q   <= row_end;
			status_q <= row_end && bad_row;
			last_q   <= 1'b1;
		end else if (cmd.rep_step) begin
			first_q  <= rep_byte_q;
			second_q <= (rep_chunk == pbrd_pkg::CNT_TWO) ? rep_byte_q : 8'd0;
			count_q  <= rep_chunk;
			done_q   <= st.rep_last && rep_end_q;
			status_q <= st.rep_last && rep_end_q && rep_status_q;
			last_q   <= st.rep_last;
		end
	end

	assign out_byte_first  = first_q;
	assign out_byte_second = second_q;
	assign byte_count      = count_q;
	assign row_done        = done_q;
	assign row_status      = status_q;
	assign last_of_item    = last_q;

endmodule
`default_nettype wire

// ===== design/packbits_row_decoder.sv =====
// Top level of the PackBits row decoder: controller, datapath and channel hookup.
// A literal byte or a row status reaches the output register in the cycle after its transfer.
// A repeat run of n bytes gives ceil(n/2) results; the controller's repeat state loads them after the repeat byte.
// Throughput: one compressed byte per cycle while the output register is free, except a repeat byte, which holds
// the input until the output register has emitted the burst, one result per cycle while the output is not stalled.
// Reset: arst_n clears the row state and the output valid at once; the row width returns to 2550.
`default_nettype none
module packbits_row_decoder (
	input  wire logic clk,
	input  wire logic arst_n,
	pbrd_in_if.sink    src,
	pbrd_out_if.source dst,
	pbrd_cfg_if.sink   cfg
);

	pbrd_pkg::cmd_t  cmd;
	pbrd_pkg::stat_t st;

	// The width register can be written in any cycle.
	assign cfg.ready = 1'b1;

	// Handshake sequencing.
	pbrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (src.valid),
		.in_ready  (src.ready),
		.out_valid (dst.valid),
		.out_ready (dst.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Decode logic and result register.
	pbrd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.in_byte         (src.in_byte),
		.row_end         (src.row_end),
		.cfg_write       (cfg.valid),
		.cfg_width       (cfg.row_width_bytes),
		.out_byte_first  (dst.out_byte_first),
		.out_byte_second (dst.out_byte_second),
		.byte_count      (dst.byte_count),
		.row_done        (dst.row_done),
		.row_status      (dst.row_status),
		.last_of_item    (dst.last_of_item)
	);

endmodule
`default_nettype wire

// ===== tb/sv/packbits_row_decoder_tb.sv =====
// Self-checking testbench for the PackBits row decoder: directed rows, random rows and backpressure.
`timescale 1ns / 100ps
module packbits_row_decoder_tb;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEM_TARGET = 460;
	localparam int PRINT_LIMIT = 40;

	// One decoded result as the output channel carries it.
	typedef struct packed {
		logic [7:0] first_b;
		logic [7:0] second_b;
		logic [1:0] count;
		logic       done;
		logic       bad;
		logic       tail;
	} decoded_t;

	// Shapes of generated rows.
	typedef enum int {ROW_GOOD, ROW_TRUNC, ROW_OVERRUN, ROW_NOOP_TAIL, ROW_NOISE} row_kind_t;

	logic clk;
	logic arst_n;

	pbrd_in_if  in_ch ();
	pbrd_out_if out_ch ();
	pbrd_cfg_if cfg_ch ();

	packbits_row_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (in_ch),
		.dst    (out_ch),
		.cfg    (cfg_ch)
	);

	// Decoder state as predicted by the testbench.
	int         width_cfg;
	logic [1:0] mode_q;
	int         lit_left;
	int         rep_left;
	int         bytes_done;
	logic       row_bad;

	decoded_t   due_results[$];
	logic [7:0] row_bytes[$];

	int cycle_count;
	int error_count;
	int items_sent;
	int hold_left;
	int stall_left;
	bit gaps_on;
	bit stalls_on;

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle counter and run timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("packbits_row_decoder_tb NOT OK");
			$finish;
		end
	end

	function automatic string fmt_result(decoded_t r);
		return $sformatf("first %02h second %02h count %0d done %0b status %0b last %0b",
			r.first_b, r.second_b, r.count, r.done, r.bad, r.tail);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	function automatic decoded_t make_result(logic [7:0] a, logic [7:0] b, logic [1:0] n);
		decoded_t r;
		r = '0;
		r.first_b = a;
		r.second_b = (n == pbrd_pkg::CNT_TWO) ? b : 8'h00;
		r.count = n;
		return r;
	endfunction

	function automatic void clear_row_state();
		mode_q = pbrd_pkg::MODE_CTRL;
		lit_left = 0;
		rep_left = 0;
		bytes_done = 0;
		row_bad = 1'b0;
	endfunction

	// Predict the results of one accepted compressed byte and queue them.
	function automatic void decode_byte(logic [7:0] b, logic row_end);
		decoded_t batch[$];
		int left;
		int c;
		int n;
		logic bad;
		if (!row_bad) begin
			if (mode_q == pbrd_pkg::MODE_LIT) begin
				batch.push_back(make_result(b, 8'h00, pbrd_pkg::CNT_ONE));
				bytes_done++;
				lit_left--;
				if (lit_left == 0)
					mode_q = pbrd_pkg::MODE_CTRL;
			end else if (mode_q == pbrd_pkg::MODE_REP) begin
				left = rep_left;
				while (left > 0) begin
					c = (left < 2) ? 1 : 2;
					batch.push_back(make_result(b, b,
						(c == 2) ? pbrd_pkg::CNT_TWO : pbrd_pkg::CNT_ONE));
					left -= c;
				end
				bytes_done += rep_left;
				rep_left = 0;
				mode_q = pbrd_pkg::MODE_CTRL;
			end else if (b < pbrd_pkg::CTRL_NOOP) begin
				n = int'(b) + 1;
				if (bytes_done + n > width_cfg) begin
					row_bad = 1'b1;
				end else begin
					lit_left = n;
					mode_q = pbrd_pkg::MODE_LIT;
				end
			end else if (b > pbrd_pkg::CTRL_NOOP) begin
				n = int'(pbrd_pkg::REP_BASE) - int'(b);
				if (bytes_done + n > width_cfg) begin
					row_bad = 1'b1;
				end else begin
					rep_left = n;
					mode_q = pbrd_pkg::MODE_REP;
				end
			end
		end
		// The row-end item closes the row and carries its status.
		if (row_end) begin
			bad = row_bad || (mode_q != pbrd_pkg::MODE_CTRL) || (bytes_done != width_cfg);
			if (batch.size() == 0)
				batch.push_back(make_result(8'h00, 8'h00, pbrd_pkg::CNT_NONE));
			batch[batch.size() - 1].done = 1'b1;
			batch[batch.size() - 1].bad = bad;
			clear_row_state();
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].tail = 1'b1;
		foreach (batch[i])
			due_results.push_back(batch[i]);
	endfunction

	// Compare one output transfer with the oldest expected result.
	task automatic check_result();
		decoded_t got;
		decoded_t want;
		got.first_b = out_ch.out_byte_first;
		got.second_b = out_ch.out_byte_second;
		got.count = out_ch.byte_count;
		got.done = out_ch.row_done;
		got.bad = out_ch.row_status;
		got.tail = out_ch.last_of_item;
		if (due_results.size() == 0) begin
			report_mismatch({"unexpected result: ", fmt_result(got)});
		end else begin
			want = due_results.pop_front();
			if (got !== want)
				report_mismatch({"got ", fmt_result(got), " want ", fmt_result(want)});
		end
	endtask

	// Output side: checks each transfer and applies random stalls and long hold-offs.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				check_result();
				if (stalls_on)
					stall_left = $urandom_range(0, 19);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one compressed byte after a random gap and wait for its transfer.
	task automatic send_byte(input logic [7:0] b, input logic row_end);
		int gap;
		gap = gaps_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.row_end <= row_end;
		do @(posedge clk); while (!in_ch.ready);
		decode_byte(b, row_end);
		items_sent++;
	endtask

	// Send the bytes of the current row, marking the last one as row end.
	task automatic send_row();
		for (int i = 0; i < row_bytes.size(); i++)
			send_byte(row_bytes[i], i == row_bytes.size() - 1);
	endtask

	// Wait until every expected result has arrived and the block has settled.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the row width while the block is idle.
	task automatic write_width(input logic [15:0] w);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.row_width_bytes <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		width_cfg = int'(w);
	endtask

	// Append well-formed runs that decode to exactly width bytes.
	function automatic void add_good_runs(input int width);
		int rem;
		int n;
		int cap;
		int pick;
		rem = width;
		while (rem > 0) begin
			pick = $urandom_range(0, 9);
			cap = ($urandom_range(0, 3) == 0) ? 128 : 8;
			if (cap > rem)
				cap = rem;
			if (pick == 0) begin
				row_bytes.push_back(pbrd_pkg::CTRL_NOOP);
			end else if (pick < 5 || cap < 2) begin
				n = $urandom_range(1, cap);
				row_bytes.push_back(8'(n - 1));
				for (int k = 0; k < n; k++)
					row_bytes.push_back(8'($urandom));
				rem -= n;
			end else begin
				n = $urandom_range(2, cap);
				row_bytes.push_back(8'(int'(pbrd_pkg::REP_BASE) - n));
				row_bytes.push_back(8'($urandom));
				rem -= n;
			end
		end
	endfunction

	// Build one row of the given shape into row_bytes.
	function automatic void build_row(input int width, input row_kind_t kind);
		int n;
		bit front_done;
		row_bytes.delete();
		front_done = 1'b0;
		if (kind == ROW_NOISE) begin
			n = $urandom_range(1, 6);
			repeat (n) row_bytes.push_back(8'($urandom));
			return;
		end
		// A run one byte longer than the row, placed first; the rest is discarded.
		if (kind == ROW_OVERRUN && width < 128 && $urandom_range(0, 1) == 1) begin
			n = width + 1;
			if (n >= 2 && $urandom_range(0, 1) == 1) begin
				row_bytes.push_back(8'(int'(pbrd_pkg::REP_BASE) - n));
				row_bytes.push_back(8'($urandom));
			end else begin
				row_bytes.push_back(8'(n - 1));
			end
			front_done = 1'b1;
		end
		add_good_runs(width);
		case (kind)
			ROW_TRUNC: begin
				n = $urandom_range(1, 3);
				while (n > 0 && row_bytes.size() > 1) begin
					void'(row_bytes.pop_back());
					n--;
				end
			end
			ROW_OVERRUN: begin
				// A full row followed by any run overflows the width.
				if (!front_done) begin
					if ($urandom_range(0, 1) == 1)
						row_bytes.push_back(8'($urandom_range(0, 8'h7F)));
					else
						row_bytes.push_back(8'($urandom_range(8'h81, 8'hFF)));
					repeat ($urandom_range(1, 2)) row_bytes.push_back(8'($urandom));
				end
			end
			ROW_NOOP_TAIL: begin
				repeat ($urandom_range(1, 3)) row_bytes.push_back(pbrd_pkg::CTRL_NOOP);
			end
			default: begin
			end
		endcase
	endfunction

	// A well-formed row at the width left by reset, built from long repeat runs.
	task automatic test_reset_width();
		int rem;
		int n;
		gaps_on = 1'b1;
		stalls_on = $urandom_range(0, 1);
		row_bytes.delete();
		rem = int'(pbrd_pkg::ROW_WIDTH_RESET);
		while (rem > 0) begin
			n = (rem > 128) ? 128 : rem;
			row_bytes.push_back(8'(int'(pbrd_pkg::REP_BASE) - n));
			row_bytes.push_back(8'($urandom));
			rem -= n;
		end
		send_row();
	endtask

	// Short rows for extreme widths, every control kind and the error cases.
	task automatic test_directed();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		write_width(16'd1);
		// One literal byte fills the row exactly.
		row_bytes = '{8'h00, 8'hFF};
		send_row();
		// A row of a single no-op produces no bytes.
		row_bytes = '{pbrd_pkg::CTRL_NOOP};
		send_row();
		// A repeat of two overflows a one-byte row; the next byte is discarded.
		row_bytes = '{8'hFF, 8'h00};
		send_row();
		write_width(16'd8);
		// Repeat of three, no-op, literal of five: a good row.
		row_bytes = '{8'hFE, 8'hAA, pbrd_pkg::CTRL_NOOP, 8'h04, 8'h01, 8'h02, 8'h03,
			8'h04, 8'h05};
		send_row();
		// The row ends in the middle of a literal run.
		row_bytes = '{8'h03, 8'h11, 8'h22};
		send_row();
		// The row ends right after a repeat control byte.
		row_bytes = '{8'hFD};
		send_row();
		// A literal of nine does not fit in eight bytes.
		row_bytes = '{8'h08, 8'h01, 8'h02};
		send_row();
		write_width(16'hFFFF);
		// The longest repeat run, in a row far short of its width.
		row_bytes = '{8'h81, 8'h55};
		send_row();
	endtask

	// The output is held off for long stretches while input keeps coming.
	task automatic test_backpressure();
		write_width(16'd128);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		hold_left = 200;
		// The longest literal run fills a 128-byte row.
		row_bytes.delete();
		row_bytes.push_back(8'h7F);
		repeat (128) row_bytes.push_back(8'($urandom));
		send_row();
		wait_drained();
		hold_left = 150;
		build_row(128, ROW_GOOD);
		send_row();
	endtask

	// Random rows over a range of widths, mostly well-formed.
	task automatic test_random_rows();
		int pick;
		int width;
		int rows;
		row_kind_t kind;
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				width = 1;
			else if (pick < 6)
				width = $urandom_range(2, 12);
			else if (pick < 9)
				width = $urandom_range(13, 60);
			else
				width = $urandom_range(100, 200);
			write_width(16'(width));
			rows = $urandom_range(2, 6);
			repeat (rows) begin
				if (items_sent >= ITEM_TARGET)
					break;
				gaps_on = $urandom_range(0, 1);
				stalls_on = $urandom_range(0, 1);
				pick = $urandom_range(0, 99);
				if (pick < 60)
					kind = ROW_GOOD;
				else if (pick < 70)
					kind = ROW_TRUNC;
				else if (pick < 80)
					kind = ROW_OVERRUN;
				else if (pick < 88)
					kind = ROW_NOOP_TAIL;
				else
					kind = ROW_NOISE;
				build_row(width, kind);
				send_row();
			end
		end
	endtask

	// Reset, run the tests in turn, then give the verdict.
	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.row_end = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.row_width_bytes = 16'h0000;
		out_ch.ready = 1'b0;
		cycle_count = 0;
		error_count = 0;
		items_sent = 0;
		hold_left = 0;
		stall_left = 0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		width_cfg = int'(pbrd_pkg::ROW_WIDTH_RESET);
		clear_row_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_width();
		test_directed();
		test_backpressure();
		test_random_rows();

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0 && due_results.size() == 0) begin
			$display("packbits_row_decoder_tb OK");
		end else begin
			$display("packbits_row_decoder_tb NOT OK");
		end
		$finish;
	end

endmodule
